// File: hdl/srd_pkg.sv
// Shared types, codes and constants for the sprite run-length decoder.
package srd_pkg;

  // Queue depth between the byte decoder and the result sequencer
  localparam int unsigned QueueDepth = 4;

  // Stream byte codes
  localparam logic [7:0] CodeEol     = 8'h00;
  localparam logic [7:0] CodeEnd     = 8'h80;
  localparam logic [7:0] CodeShadow  = 8'hC0;
  localparam logic [7:0] CodeLongFil = 8'hC1;
  localparam logic [1:0] ShadowMask  = 2'd3;

  // Result kinds
  localparam logic [1:0] KindColour = 2'd0;
  localparam logic [1:0] KindShadow = 2'd1;
  localparam logic [1:0] KindEnd    = 2'd2;

  // End status codes
  localparam logic EndSeen      = 1'b0;
  localparam logic EndTruncated = 1'b1;

  // Register indexes
  localparam logic [1:0] RegImageWidth   = 2'd0;
  localparam logic [1:0] RegMirror       = 2'd1;
  localparam logic [1:0] RegShadowEnable = 2'd2;

  // Decoder phase, one-hot
  typedef enum logic [5:0] {
    PhCmd     = 6'b000001,
    PhLit     = 6'b000010,
    PhShCnt   = 6'b000100,
    PhShExt   = 6'b001000,
    PhLongCnt = 6'b010000,
    PhFill    = 6'b100000
  } phase_e;

  // Configuration seen by the decoder
  typedef struct packed {
    logic        mirror;
    logic        shadow_en;
    logic        geom_load;   // a geometry register is being written this cycle
    logic [15:0] line_start;  // line start for the settings being written
    logic [15:0] cur_start;   // line start for the settings in force
  } cfg_t;

  // One decoded byte: an optional run, then an optional end marker
  typedef struct packed {
    logic        has_run;
    logic        shadow;
    logic [15:0] x_start;
    logic [15:0] row;
    logic [7:0]  run_length;
    logic [7:0]  palette_index;
    logic        has_end;
    logic        end_status;
  } qent_t;

endpackage

// File: hdl/srd_if.sv
// Valid/ready channel interfaces for stream bytes and decoded results.
interface srd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface srd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        end_status;
  logic [15:0] x_start;
  logic [15:0] row;
  logic [7:0]  run_length;
  logic [7:0]  palette_index;
  logic        last;

  modport source (output valid, output kind, output end_status, output x_start,
                  output row, output run_length, output palette_index, output last,
                  input ready);
  modport sink   (input valid, input kind, input end_status, input x_start,
                  input row, input run_length, input palette_index, input last,
                  output ready);
endinterface

// File: hdl/srd_front.sv
// Byte decoder: tracks stream phase, column and row, and classifies each beat.
module srd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  srd_pkg::cfg_t cfg_i,
  input  logic          in_fire_i,
  input  logic [7:0]    data_byte_i,
  input  logic          last_byte_i,
  output logic          enq_o,
  output srd_pkg::qent_t ent_o
);
  import srd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  remaining_q, remaining_d;
  logic [15:0] column_q, column_d;
  logic [15:0] line_q, line_d;
  logic        finished_q, finished_d;

  logic        run_v, run_sh, end_v, end_st, eol;
  logic [7:0]  run_len, run_pal, adv;
  logic [7:0]  rem_dec;

  assign rem_dec = remaining_q - 8'd1;

  // Classify the byte against the current phase
  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    finished_d  = finished_q;
    run_v   = 1'b0;
    run_sh  = 1'b0;
    run_len = 8'd0;
    run_pal = 8'd0;
    adv     = 8'd0;
    end_v   = 1'b0;
    end_st  = EndSeen;
    eol     = 1'b0;

    unique case (phase_q)
      PhLit: begin
        run_v   = 1'b1;
        run_len = 8'd1;
        run_pal = data_byte_i;
        adv     = 8'd1;
        remaining_d = rem_dec;
        if (rem_dec == 8'd0) phase_d = PhCmd;
      end
      PhShCnt: begin
        if ((data_byte_i[1:0] & ShadowMask) != 2'd0) begin
          run_v   = cfg_i.shadow_en;
          run_sh  = 1'b1;
          run_len = {6'd0, data_byte_i[1:0]};
          adv     = {6'd0, data_byte_i[1:0]};
          phase_d = PhCmd;
        end else begin
          phase_d = PhShExt;
        end
      end
      PhShExt: begin
        run_v   = cfg_i.shadow_en && (data_byte_i != 8'd0);
        run_sh  = 1'b1;
        run_len = data_byte_i;
        adv     = data_byte_i;
        phase_d = PhCmd;
      end
      PhLongCnt: begin
        remaining_d = data_byte_i;
        phase_d     = PhFill;
      end
      PhFill: begin
        run_v   = (remaining_q != 8'd0);
        run_len = remaining_q;
        run_pal = data_byte_i;
        adv     = remaining_q;
        remaining_d = 8'd0;
        phase_d     = PhCmd;
      end
      PhCmd: begin
        priority if (data_byte_i == CodeEol) begin
          eol = 1'b1;
        end else if (data_byte_i < CodeEnd) begin
          remaining_d = data_byte_i;
          phase_d     = PhLit;
        end else if (data_byte_i == CodeEnd) begin
          end_v      = 1'b1;
          finished_d = 1'b1;
        end else if (data_byte_i < CodeShadow) begin
          adv = data_byte_i - CodeEnd;
        end else if (data_byte_i == CodeShadow) begin
          phase_d = PhShCnt;
        end else if (data_byte_i == CodeLongFil) begin
          phase_d = PhLongCnt;
        end else begin
          remaining_d = data_byte_i - CodeShadow;
          phase_d     = PhFill;
        end
      end
      default: phase_d = PhCmd;
    endcase

    // Truncated stream: last byte that is not the end code
    if (last_byte_i && !end_v) begin
      end_v      = 1'b1;
      end_st     = EndTruncated;
      finished_d = 1'b1;
    end
  end

  // Column and row update
  always_comb begin
    line_d   = line_q;
    column_d = column_q;
    if (cfg_i.geom_load) begin
      column_d = cfg_i.line_start;
    end else if (in_fire_i && !finished_q) begin
      if (eol) begin
        line_d   = line_q + 16'd1;
        column_d = cfg_i.cur_start;
      end else if (cfg_i.mirror) begin
        column_d = column_q - {8'd0, adv};
      end else begin
        column_d = column_q + {8'd0, adv};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhCmd;
      remaining_q <= 8'd0;
      column_q    <= 16'd0;
      line_q      <= 16'd0;
      finished_q  <= 1'b0;
    end else begin
      column_q <= column_d;
      line_q   <= line_d;
      if (in_fire_i && !finished_q) begin
        phase_q     <= phase_d;
        remaining_q <= remaining_d;
        finished_q  <= finished_d;
      end
    end
  end

  // Entry toward the queue
  assign enq_o = in_fire_i && !finished_q && (run_v || end_v);
  always_comb begin
    ent_o.has_run       = run_v;
    ent_o.shadow        = run_sh;
    ent_o.x_start       = column_q;
    ent_o.row           = line_q;
    ent_o.run_length    = run_len;
    ent_o.palette_index = run_sh ? 8'd0 : run_pal;
    ent_o.has_end       = end_v;
    ent_o.end_status    = end_st;
  end

endmodule

// File: hdl/srd_queue.sv
// Small register FIFO between the byte decoder and the result sequencer.
module srd_queue #(
  parameter int unsigned Depth = srd_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  srd_pkg::qent_t wr_data_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output srd_pkg::qent_t rd_data_o,
  output logic           empty_o
);
  import srd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  qent_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o    = (count_q == FullCnt);
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      if (do_rd) rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      if (do_wr && !do_rd)      count_q <= count_q + CntW'(1);
      else if (do_rd && !do_wr) count_q <= count_q - CntW'(1);
    end
  end

endmodule

// File: hdl/srd_back.sv
// Result sequencer: splits each queued entry into run and end result beats.
module srd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  srd_pkg::qent_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  srd_out_if.source      out_o
);
  import srd_pkg::*;

  logic end_sel_q;   // run of the head entry already delivered
  logic show_run, fire;

  assign show_run = head_i.has_run && !end_sel_q;
  assign fire     = out_o.valid && out_o.ready;

  // Drive the result beat from the head entry
  always_comb begin
    out_o.valid = !empty_i;
    if (show_run) begin
      out_o.kind          = head_i.shadow ? KindShadow : KindColour;
      out_o.end_status    = EndSeen;
      out_o.x_start       = head_i.x_start;
      out_o.row           = head_i.row;
      out_o.run_length    = head_i.run_length;
      out_o.palette_index = head_i.palette_index;
      out_o.last          = !head_i.has_end;
    end else begin
      out_o.kind          = KindEnd;
      out_o.end_status    = head_i.end_status;
      out_o.x_start       = 16'd0;
      out_o.row           = 16'd0;
      out_o.run_length    = 8'd0;
      out_o.palette_index = 8'd0;
      out_o.last          = 1'b1;
    end
  end

  // Pop once the final beat of the entry goes out
  assign pop_o = fire && out_o.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_sel_q <= 1'b0;
    end else if (fire) begin
      end_sel_q <= !out_o.last;
    end
  end

endmodule

// File: hdl/sprite_rle_decoder_core.sv
// Top level of the sprite run-length decoder: register port, decoder, queue, sequencer.
// The core takes one stream byte per cycle as long as the result queue has room and
// reports the pixel runs it describes. A run is queued when its byte is accepted and
// output after entries ahead of it; each result is one output beat, so a byte giving
// a run and a truncation end yields two beats. A QueueDepth-entry register FIFO parts
// the decoder and result sequencer, so input flows while results wait; sustained input
// rate is one byte per cycle whenever the output side takes one beat per cycle and
// bytes average at most one result. The user must write registers (image_width at 0x0,
// mirror at 0x4, shadow_enable at 0x8) only while idle; the core does not enforce it.
// Writing a geometry register moves the column to the new line start.
module sprite_rle_decoder_core #(
  parameter int unsigned QueueDepth = srd_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  srd_in_if.sink      in_i,
  srd_out_if.source   out_o
);
  import srd_pkg::*;

  logic [15:0] image_width_q;
  logic        mirror_q, shadow_en_q;
  logic [15:0] width_n;
  logic        mirror_n, cfg_wr;
  logic [1:0]  reg_idx;
  cfg_t        cfg;

  logic   full, empty, enq, pop, in_fire;
  qent_t  enq_ent, head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  // Register write and line start for the written settings
  assign width_n  = (cfg_wr && reg_idx == RegImageWidth) ? pwdata[15:0] : image_width_q;
  assign mirror_n = (cfg_wr && reg_idx == RegMirror) ? pwdata[0] : mirror_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= 16'd1;
      mirror_q      <= 1'b0;
      shadow_en_q   <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegImageWidth:   image_width_q <= pwdata[15:0];
        RegMirror:       mirror_q      <= pwdata[0];
        RegShadowEnable: shadow_en_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      RegImageWidth:   prdata = {16'd0, image_width_q};
      RegMirror:       prdata = {31'd0, mirror_q};
      RegShadowEnable: prdata = {31'd0, shadow_en_q};
      default:         prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.mirror     = mirror_q;
    cfg.shadow_en  = shadow_en_q;
    cfg.geom_load  = cfg_wr && (reg_idx == RegImageWidth || reg_idx == RegMirror);
    cfg.line_start = mirror_n ? (width_n - 16'd1) : 16'd0;
    cfg.cur_start  = mirror_q ? (image_width_q - 16'd1) : 16'd0;
  end

  // Input beat acceptance
  assign in_i.ready = !full;
  assign in_fire    = in_i.valid && !full;

  srd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_fire_i   (in_fire),
    .data_byte_i (in_i.data_byte),
    .last_byte_i (in_i.last_byte),
    .enq_o       (enq),
    .ent_o       (enq_ent)
  );

  srd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (enq),
    .wr_data_i (enq_ent),
    .full_o    (full),
    .rd_en_i   (pop),
    .rd_data_o (head),
    .empty_o   (empty)
  );

  srd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
